// ===== rtl/core/mme_pkg.sv =====
`default_nettype none

package mme_pkg;

    localparam int IDX_W     = 3;
    localparam int DIM_W     = 4;
    localparam int SUM_W     = 35;
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_C_W  = 2 * IDX_W + 1;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

    typedef struct packed {
        op_t              kind;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } cmd_t;

    typedef struct packed {
        logic             first;
        logic             last_k;
        logic             last_c;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/mme_ram.sv =====
`default_nettype none

module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                clk,
    input  wire logic                                we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                    wdata,
    input  wire logic                                re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mme_front.sv =====
`default_nettype none

module mme_front
    import mme_pkg::*;
#(
    parameter int MAX_DIM       = 8,
    parameter int ELEMENT_WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               operation,
    input  wire logic [IDX_W-1:0]         row_index,
    input  wire logic [IDX_W-1:0]         col_index,
    input  wire logic [ELEMENT_WIDTH-1:0] element_value,
    output logic                          cmd_valid,
    input  wire logic                     cmd_ready,
    output cmd_t                          cmd,
    output logic [ELEMENT_WIDTH-1:0]      cmd_value
);

    localparam int QD = 2;

    cmd_t                     q_cmd_reg [QD];
    logic [ELEMENT_WIDTH-1:0] q_val_reg [QD];
    logic                     wr_ptr_reg;
    logic                     rd_ptr_reg;
    logic [1:0]               cnt_reg;
    logic [1:0]               cnt_next;
    logic                     in_range;
    logic                     keep;
    logic                     push;
    logic                     pop;
    cmd_t                     cmd_in;

    assign in_range = ({1'b0, row_index} < DIM_W'(MAX_DIM))
                   && ({1'b0, col_index} < DIM_W'(MAX_DIM));

    always_comb
    begin
        case (op_t'(operation))
            OP_WRITE_A: keep = in_range;
            OP_WRITE_B: keep = in_range;
            OP_COMPUTE: keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    assign cmd_in.kind = op_t'(operation);
    assign cmd_in.row  = row_index;
    assign cmd_in.col  = col_index;

    assign in_ready  = (cnt_reg != 2'(QD));
    assign push      = in_valid && in_ready && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_cmd_reg[rd_ptr_reg];
    assign cmd_value = q_val_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_cmd_reg[wr_ptr_reg] <= cmd_in;
            q_val_reg[wr_ptr_reg] <= element_value;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mme_back.sv =====
`default_nettype none

module mme_back
    import mme_pkg::*;
#(
    parameter int MAX_DIM       = 8,
    parameter int ELEMENT_WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [DIM_W-1:0]         dim_m,
    input  wire logic [DIM_W-1:0]         dim_n,
    input  wire logic [DIM_W-1:0]         dim_k,
    input  wire logic                     cmd_valid,
    output logic                          cmd_ready,
    input  wire cmd_t                     cmd,
    input  wire logic [ELEMENT_WIDTH-1:0] cmd_value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [IDX_W-1:0]              out_row,
    output logic [IDX_W-1:0]              out_col,
    output logic signed [SUM_W-1:0]       dot_sum,
    output logic                          last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int PW    = 2 * ELEMENT_WIDTH;
    localparam int XW    = PW > SUM_W ? PW : SUM_W;
    localparam logic [ADDR_C_W-1:0] DIM_C = ADDR_C_W'(MAX_DIM);

    back_state_t state_reg;
    back_state_t state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] kk_reg, kk_next;

    logic stall;
    logic issue;
    logic a_we;
    logic b_we;
    logic last_i;
    logic last_j;
    logic last_k;
    logic dims_ok;

    logic [ADDR_C_W-1:0]      wr_addr_full;
    logic [ADDR_C_W-1:0]      a_raddr_full;
    logic [ADDR_C_W-1:0]      b_raddr_full;
    logic [ELEMENT_WIDTH-1:0] a_rdata;
    logic [ELEMENT_WIDTH-1:0] b_rdata;

    logic                 s1_valid_reg;
    tag_t                 s1_tag_reg;
    tag_t                 tag_issue;
    logic                 s2_valid_reg;
    tag_t                 s2_tag_reg;
    logic signed [PW-1:0] s2_prod_reg;
    logic signed [PW-1:0] prod;
    logic signed [XW-1:0] prod_x;
    logic [SUM_W-1:0]     acc_reg;
    logic [SUM_W-1:0]     sum;

    logic                 out_valid_reg;
    logic [IDX_W-1:0]     out_row_reg;
    logic [IDX_W-1:0]     out_col_reg;
    logic [SUM_W-1:0]     out_sum_reg;
    logic                 out_last_reg;

    assign stall   = out_valid_reg && !out_ready;
    assign last_i  = ({1'b0, i_reg}  == (dim_m - DIM_W'(1)));
    assign last_j  = ({1'b0, j_reg}  == (dim_n - DIM_W'(1)));
    assign last_k  = ({1'b0, kk_reg} == (dim_k - DIM_W'(1)));
    assign dims_ok = (dim_m != '0) && (dim_n != '0) && (dim_k != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            kk_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            kk_reg    <= kk_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        kk_next    = kk_reg;
        cmd_ready  = 1'b0;
        a_we       = 1'b0;
        b_we       = 1'b0;
        issue      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        OP_WRITE_A: a_we = 1'b1;
                        OP_WRITE_B: b_we = 1'b1;
                        OP_COMPUTE:
                        begin
                            if (dims_ok)
                            begin
                                state_next = BK_RUN;
                                i_next     = '0;
                                j_next     = '0;
                                kk_next    = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_RUN:
            begin
                if (!stall)
                begin
                    issue = 1'b1;
                    if (last_k)
                    begin
                        kk_next = '0;
                        if (last_j)
                        begin
                            j_next = '0;
                            if (last_i)
                            begin
                                i_next     = '0;
                                state_next = BK_IDLE;
                            end
                            else
                            begin
                                i_next = i_reg + IDX_W'(1);
                            end
                        end
                        else
                        begin
                            j_next = j_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        kk_next = kk_reg + IDX_W'(1);
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign wr_addr_full = ADDR_C_W'(cmd.row) * DIM_C + ADDR_C_W'(cmd.col);
    assign a_raddr_full = ADDR_C_W'(i_reg) * DIM_C + ADDR_C_W'(kk_reg);
    assign b_raddr_full = ADDR_C_W'(kk_reg) * DIM_C + ADDR_C_W'(j_reg);

    mme_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (DEPTH)
    ) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (wr_addr_full[AW-1:0]),
        .wdata (cmd_value),
        .re    (issue),
        .raddr (a_raddr_full[AW-1:0]),
        .rdata (a_rdata)
    );

    mme_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (DEPTH)
    ) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (wr_addr_full[AW-1:0]),
        .wdata (cmd_value),
        .re    (issue),
        .raddr (b_raddr_full[AW-1:0]),
        .rdata (b_rdata)
    );

    assign tag_issue.first  = (kk_reg == '0);
    assign tag_issue.last_k = last_k;
    assign tag_issue.last_c = last_i && last_j;
    assign tag_issue.row    = i_reg;
    assign tag_issue.col    = j_reg;

    assign prod   = $signed(a_rdata) * $signed(b_rdata);
    assign prod_x = XW'(s2_prod_reg);
    assign sum    = (s2_tag_reg.first ? '0 : acc_reg) + prod_x[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_tag_reg.last_k;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s1_tag_reg  <= tag_issue;
            s2_tag_reg  <= s1_tag_reg;
            s2_prod_reg <= prod;
            if (s2_valid_reg)
            begin
                acc_reg <= sum;
            end
            if (s2_valid_reg && s2_tag_reg.last_k)
            begin
                out_row_reg  <= s2_tag_reg.row;
                out_col_reg  <= s2_tag_reg.col;
                out_sum_reg  <= sum;
                out_last_reg <= s2_tag_reg.last_c;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign dot_sum   = out_sum_reg;
    assign last      = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/matrix_multiply_engine_unit.sv =====
// Load beat: registered into the queue, then written to its store the cycle the back end takes it.
// Compute beat: one multiply-accumulate per cycle in the back end while the output does not stall,
// through the single read port of each store; each result passes the store read, product and output registers in turn.
// Output stalls freeze the whole multiply-accumulate pipe.
// Reset: sizes return to 8, queue and pipe empty; store contents undefined until loaded.
`default_nettype none

module matrix_multiply_engine_unit
    import mme_pkg::*;
#(
    parameter int MAX_DIM       = 8,
    parameter int ELEMENT_WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [DIM_W-1:0]         cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               operation,
    input  wire logic [IDX_W-1:0]         row_index,
    input  wire logic [IDX_W-1:0]         col_index,
    input  wire logic signed [ELEMENT_WIDTH-1:0] element_value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [IDX_W-1:0]              out_row,
    output logic [IDX_W-1:0]              out_col,
    output logic signed [SUM_W-1:0]       dot_sum,
    output logic                          last
);

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    logic [DIM_W-1:0]         rows_a_reg;
    logic [DIM_W-1:0]         cols_b_reg;
    logic [DIM_W-1:0]         inner_dim_reg;
    logic [DIM_W-1:0]         dim_m;
    logic [DIM_W-1:0]         dim_n;
    logic [DIM_W-1:0]         dim_k;
    logic                     cmd_valid;
    logic                     cmd_ready;
    cmd_t                     cmd;
    logic [ELEMENT_WIDTH-1:0] cmd_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                CFG_COLS_B:    cols_b_reg    <= cfg_data;
                CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign dim_m = (rows_a_reg    > DIM_MAX) ? DIM_MAX : rows_a_reg;
    assign dim_n = (cols_b_reg    > DIM_MAX) ? DIM_MAX : cols_b_reg;
    assign dim_k = (inner_dim_reg > DIM_MAX) ? DIM_MAX : inner_dim_reg;

    mme_front #(
        .MAX_DIM       (MAX_DIM),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .cmd_value     (cmd_value)
    );

    mme_back #(
        .MAX_DIM       (MAX_DIM),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dim_m     (dim_m),
        .dim_n     (dim_n),
        .dim_k     (dim_k),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cmd_value (cmd_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_row   (out_row),
        .out_col   (out_col),
        .dot_sum   (dot_sum),
        .last      (last)
    );

    // unused op codes never reach the back end
    a_no_null_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> cmd.kind != OP_NONE)
        else $error("null command queued");

    // out-of-range loads are dropped at the front
    a_load_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (cmd.kind == OP_WRITE_A || cmd.kind == OP_WRITE_B)
        |-> ({1'b0, cmd.row} < DIM_MAX) && ({1'b0, cmd.col} < DIM_MAX))
        else $error("out-of-range load queued");

    // an accepted compute beat is queued
    a_compute_queued: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == OP_COMPUTE |=> cmd_valid)
        else $error("compute beat lost");

endmodule

`default_nettype wire
